FILE: rtl/software_timer_pool_unit_macros.svh
// Assertion macros shared by the timer pool RTL.
// Depends on nothing; the including module must have clk and rst in scope.
`ifndef SOFTWARE_TIMER_POOL_UNIT_MACROS_SVH
`define SOFTWARE_TIMER_POOL_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define STP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/stp_pkg.sv
// Shared types and constants for the software timer pool.
// Used by software_timer_pool_unit; depends on nothing.
`default_nettype none

package stp_pkg;

  localparam int TIMERS_DEF    = 32;
  localparam int TICK_BITS_DEF = 16;

  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_ALLOC  = 3'd1;
  localparam logic [2:0] ACT_CREATE = 3'd2;
  localparam logic [2:0] ACT_POLL   = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_POLL  = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [4:0]  slot;
    logic [15:0] ticks;
    logic        repeating;
  } stp_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       ok;
    logic [4:0] timer_index;
    logic       counting;
    logic       expired;
    logic       periodic;
    logic       allocated;
    logic       last;
  } stp_rsp_t;

  typedef struct packed {
    logic allocated;
    logic periodic;
    logic expired;
    logic counting;
  } stp_flags_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POLL,
    ST_CLEAR,
    ST_WALK
  } stp_state_t;

endpackage

`default_nettype wire

FILE: rtl/stp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module stp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/software_timer_pool_unit.sv
// Top level of the software timer pool: sequencer, slot RAM and result register.
// Depends on stp_pkg, stp_ram and software_timer_pool_unit_macros.svh.
//
//   channel   signals              direction  beat taken when
//   request   start, busy, req     in         start high and busy low at a clock edge
//   result    rsp_valid, rsp       out        every cycle rsp_valid is high
//
// Allocate and create finish at the accepting edge; their reply shows up in the
// next cycle and busy never rises. Poll keeps busy high for one cycle (the slot
// RAM read) and replies at the end of it. Clear keeps busy high for one cycle
// and gives no result. Tick keeps busy high while its walk runs, reading no
// slot with an empty pool: the walk reads one slot per cycle through the single
// RAM read port while the slot read in the previous cycle is updated, and a
// closing cycle releases the held event, which shows up just after busy falls.
// The result receiver cannot stall. Reset
// (rst, synchronous) clears the sequencer, the slot count and one valid bit per
// slot; a slot whose valid bit is clear reads as all zero, so no clearing pass
// is needed after reset.
`default_nettype none
`include "software_timer_pool_unit_macros.svh"

module software_timer_pool_unit
  import stp_pkg::*;
#(
  parameter int TIMERS    = TIMERS_DEF,
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire stp_req_t req,
  output logic          rsp_valid,
  output stp_rsp_t      rsp
);

  // Index width for slots, width of the slot count, counter width, RAM entry width.
  localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int UW = $clog2(TIMERS + 1);
  localparam int CW = TICK_BITS + 1;
  localparam int EW = 4 + CW + TICK_BITS;

  // Control state.
  stp_state_t          state, state_next;
  logic [UW-1:0]       used_slots, used_slots_next;
  logic [(1<<IW)-1:0]  valid;
  logic                rvalid;
  logic [UW-1:0]       rd_idx, rd_idx_next;
  logic                pv, pv_next;
  logic [IW-1:0]       pidx, pidx_next;
  logic                pend_valid, pend_valid_next;
  logic                rsp_valid_next;

  // Payload registers.
  stp_req_t            cmd, cmd_next;
  stp_rsp_t            pend, pend_next;
  stp_rsp_t            rsp_next;

  // Slot RAM port signals.
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [EW-1:0]       ram_wdata;
  logic [IW-1:0]       ram_raddr;
  logic [EW-1:0]       ram_rdata;

  // Decoded entry of the slot read in the previous cycle.
  logic [EW-1:0]       ent;
  stp_flags_t          ent_flags;
  logic [CW-1:0]       ent_cnt;
  logic [TICK_BITS-1:0] ent_per;

  logic                accept;
  logic                walk_issue;
  logic                cmd_in_range;
  logic [IW-1:0]       cmd_idx;
  logic [TICK_BITS-1:0] req_ticks;
  logic [TICK_BITS-1:0] cmd_ticks;

  // Working values of the datapath.
  stp_flags_t          f;
  logic [CW-1:0]       cnt_new;
  logic [TICK_BITS-1:0] per_new;
  logic                fire;

  stp_ram #(
    .WIDTH (EW),
    .DEPTH (TIMERS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // A slot that was never written reads as its reset value, all zero.
  assign ent       = rvalid ? ram_rdata : '0;
  assign ent_flags = stp_flags_t'(ent[EW-1 -: 4]);
  assign ent_cnt   = ent[TICK_BITS +: CW];
  assign ent_per   = ent[TICK_BITS-1:0];

  assign walk_issue   = (rd_idx < used_slots);
  assign cmd_in_range = ({2'b00, cmd.slot} < 7'(TIMERS));
  assign cmd_idx      = IW'(cmd.slot);
  assign req_ticks    = TICK_BITS'(req.ticks);
  assign cmd_ticks    = TICK_BITS'(cmd.ticks);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.action)
            ACT_TICK:  state_next = ST_WALK;
            ACT_POLL:  state_next = ST_POLL;
            ACT_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_POLL:  state_next = ST_IDLE;
      ST_CLEAR: state_next = ST_IDLE;
      ST_WALK: begin
        if (!walk_issue && !pv) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath, RAM port and result register values.
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_raddr       = IW'(req.slot);
    used_slots_next = used_slots;
    rd_idx_next     = rd_idx;
    pv_next         = 1'b0;
    pidx_next       = pidx;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    rsp_next        = rsp;
    rsp_valid_next  = 1'b0;
    cmd_next        = accept ? req : cmd;
    f               = ent_flags;
    cnt_new         = ent_cnt;
    per_new         = ent_per;
    fire            = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.action)
            ACT_ALLOC, ACT_CREATE: begin
              rsp_next       = '0;
              rsp_next.kind  = KIND_ALLOC;
              rsp_next.last  = 1'b1;
              rsp_valid_next = 1'b1;
              if (used_slots < UW'(TIMERS)) begin
                // Slots above the count are never touched, so the new entry is built fresh.
                f           = '0;
                f.allocated = 1'b1;
                f.periodic  = (req.action == ACT_CREATE);
                per_new     = (f.periodic && req.repeating) ? req_ticks : '0;
                ram_we      = 1'b1;
                ram_waddr   = used_slots[IW-1:0];
                ram_wdata   = {f, {CW{1'b0}}, per_new};
                used_slots_next      = used_slots + 1'b1;
                rsp_next.ok          = 1'b1;
                rsp_next.timer_index = 5'(used_slots);
                rsp_next.counting    = f.counting;
                rsp_next.expired     = f.expired;
                rsp_next.periodic    = f.periodic;
                rsp_next.allocated   = f.allocated;
              end
            end
            ACT_TICK: begin
              rd_idx_next     = '0;
              pend_valid_next = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_POLL: begin
        // Only an allocated slot that is neither counting nor expired is started.
        if (cmd_in_range && f.allocated && !f.expired && !f.counting) begin
          f.counting = 1'b1;
          ram_we     = 1'b1;
          ram_waddr  = cmd_idx;
          ram_wdata  = {f, CW'(cmd_ticks), ent_per};
        end
        rsp_next             = '0;
        rsp_next.kind        = KIND_POLL;
        rsp_next.timer_index = cmd.slot;
        rsp_next.last        = 1'b1;
        if (cmd_in_range) begin
          rsp_next.counting  = f.counting;
          rsp_next.expired   = f.expired;
          rsp_next.periodic  = f.periodic;
          rsp_next.allocated = f.allocated;
        end
        rsp_valid_next = 1'b1;
      end

      ST_CLEAR: begin
        if (cmd_in_range && f.allocated) begin
          f.counting = 1'b0;
          f.expired  = 1'b0;
          ram_we     = 1'b1;
          ram_waddr  = cmd_idx;
          ram_wdata  = {f, {CW{1'b0}}, ent_per};
        end
      end

      ST_WALK: begin
        ram_raddr = rd_idx[IW-1:0];
        if (walk_issue) begin
          rd_idx_next = rd_idx + 1'b1;
          pv_next     = 1'b1;
          pidx_next   = rd_idx[IW-1:0];
        end
        if (pv) begin
          if (f.counting || f.periodic) begin
            cnt_new = ent_cnt - 1'b1;
            if (ent_cnt == '0) begin
              f.expired  = 1'b1;
              f.counting = 1'b0;
              if (f.periodic) begin
                cnt_new = CW'(ent_per);
                fire    = 1'b1;
              end
            end
          end
          ram_we    = 1'b1;
          ram_waddr = pidx;
          ram_wdata = {f, cnt_new, ent_per};
          // An event is held back one step so that the final one can carry last.
          if (fire) begin
            if (pend_valid) begin
              rsp_next       = pend;
              rsp_valid_next = 1'b1;
            end
            pend_next             = '0;
            pend_next.kind        = KIND_EVENT;
            pend_next.timer_index = 5'(pidx);
            pend_next.counting    = f.counting;
            pend_next.expired     = f.expired;
            pend_next.periodic    = f.periodic;
            pend_next.allocated   = f.allocated;
            pend_valid_next       = 1'b1;
          end
        end
        if (!walk_issue && !pv && pend_valid) begin
          rsp_next        = pend;
          rsp_next.last   = 1'b1;
          rsp_valid_next  = 1'b1;
          pend_valid_next = 1'b0;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used_slots <= '0;
      valid      <= '0;
      rvalid     <= 1'b0;
      rd_idx     <= '0;
      pv         <= 1'b0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      used_slots <= used_slots_next;
      rvalid     <= valid[ram_raddr];
      if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
      end
      rd_idx     <= rd_idx_next;
      pv         <= pv_next;
      pend_valid <= pend_valid_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd  <= cmd_next;
    pend <= pend_next;
    rsp  <= rsp_next;
    pidx <= pidx_next;
  end

  `STP_ASSERT_NOW(a_used_bound, 1'b1, used_slots <= UW'(TIMERS), "slot count above pool size")
  `STP_ASSERT_NOW(a_ok_only_alloc, rsp_valid && rsp.kind != KIND_ALLOC, !rsp.ok, "ok set outside an allocation reply")
  `STP_ASSERT_NEXT(a_poll_busy, accept && req.action == ACT_POLL, busy && state == ST_POLL, "poll did not enter its read cycle")
  `STP_ASSERT_NOW(a_walk_index, state == ST_WALK && pv, UW'(pidx) < used_slots, "walk touched a slot beyond the count")
  `STP_ASSERT_NOW(a_pend_walk, pend_valid, state == ST_WALK, "held event outside a tick walk")

endmodule

`default_nettype wire

FILE: bench/stp_timer_pool_mirror_pkg.sv
// Self-checking mirror of the software timer pool, used by the testbench top.
// Depends on stp_pkg for the request, result and slot flag types.
package stp_timer_pool_mirror_pkg;
  import stp_pkg::*;

  class timer_pool_mirror;
    logic [16:0] countdown [TIMERS_DEF];
    logic [15:0] period [TIMERS_DEF];
    stp_flags_t  flags [TIMERS_DEF];
    int unsigned slots_used;
    stp_rsp_t    awaited [$];
    int unsigned mismatch_count;

    function new();
      foreach (countdown[i]) begin
        countdown[i] = '0;
        period[i]    = '0;
        flags[i]     = '0;
      end
      slots_used     = 0;
      mismatch_count = 0;
    endfunction

    function void push_reply(logic [1:0] kind, logic ok, int unsigned idx, stp_flags_t f);
      stp_rsp_t r;
      r.kind        = kind;
      r.ok          = ok;
      r.timer_index = 5'(idx);
      r.counting    = f.counting;
      r.expired     = f.expired;
      r.periodic    = f.periodic;
      r.allocated   = f.allocated;
      r.last        = 1'b0;
      awaited.push_back(r);
    endfunction

    // Apply one accepted command to the mirrored pool and queue its results.
    function void note_command(stp_req_t c);
      stp_flags_t  f;
      stp_rsp_t    tail;
      logic [16:0] prev;
      int unsigned s;
      int          queued;
      queued = awaited.size();
      case (c.action)
        ACT_TICK: begin
          for (int i = 0; i < slots_used; i++) begin
            f = flags[i];
            if (f.counting || f.periodic) begin
              prev         = countdown[i];
              countdown[i] = prev - 17'd1;
              if (prev == 17'd0) begin
                f.expired  = 1'b1;
                f.counting = 1'b0;
                flags[i]   = f;
                // Tasks reload and announce themselves; delay timers stop silently.
                if (f.periodic) begin
                  countdown[i] = {1'b0, period[i]};
                  push_reply(KIND_EVENT, 1'b0, i, f);
                end
              end
            end
          end
        end
        ACT_ALLOC, ACT_CREATE: begin
          if (slots_used >= TIMERS_DEF || flags[slots_used].allocated) begin
            push_reply(KIND_ALLOC, 1'b0, 0, '0);
          end else begin
            s = slots_used;
            flags[s].allocated = 1'b1;
            slots_used++;
            if (c.action == ACT_CREATE) begin
              period[s]         = c.repeating ? c.ticks : 16'd0;
              flags[s].periodic = 1'b1;
            end
            push_reply(KIND_ALLOC, 1'b1, s, flags[s]);
          end
        end
        ACT_POLL: begin
          f = flags[c.slot];
          if (f.allocated && !f.expired && !f.counting) begin
            countdown[c.slot] = {1'b0, c.ticks};
            f.counting        = 1'b1;
            flags[c.slot]     = f;
          end
          push_reply(KIND_POLL, 1'b0, c.slot, f);
        end
        ACT_CLEAR: begin
          if (flags[c.slot].allocated) begin
            flags[c.slot].counting = 1'b0;
            flags[c.slot].expired  = 1'b0;
            countdown[c.slot]      = '0;
          end
        end
        default: ;
      endcase
      if (awaited.size() > queued) begin
        tail      = awaited.pop_back();
        tail.last = 1'b1;
        awaited.push_back(tail);
      end
    endfunction

    function string describe(stp_rsp_t r);
      return $sformatf("kind=%0d ok=%0d idx=%0d cnt=%0d exp=%0d per=%0d alloc=%0d last=%0d",
                       r.kind, r.ok, r.timer_index, r.counting, r.expired, r.periodic,
                       r.allocated, r.last);
    endfunction

    // Compare one result beat with the oldest queued result.
    function void check_reply(stp_rsp_t got);
      stp_rsp_t want;
      if (awaited.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result %s", $realtime, describe(got));
      end else begin
        want = awaited.pop_front();
        if (got.kind !== want.kind || got.ok !== want.ok ||
            got.timer_index !== want.timer_index || got.counting !== want.counting ||
            got.expired !== want.expired || got.periodic !== want.periodic ||
            got.allocated !== want.allocated || got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                     $realtime, describe(want), describe(got));
        end
      end
    endfunction
  endclass

endpackage

FILE: bench/tb_top.sv
// Testbench top for software_timer_pool_unit: clock, reset, command driver and result monitor.
// Depends on stp_pkg, stp_timer_pool_mirror_pkg and the timer pool RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stp_pkg::*;
  import stp_timer_pool_mirror_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 360;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  // A tick walks every used slot; this covers the longest walk, over a full pool.
  localparam int unsigned SETTLE_CYCLES = 40;
  // Highest encodable action; everything above ACT_CLEAR is an unused code.
  localparam logic [2:0]  ACT_TOP       = 3'd7;
  localparam int unsigned SLOT_TOP      = TIMERS_DEF - 1;

  logic     clk;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  stp_req_t req = '0;
  logic     busy;
  logic     rsp_valid;
  stp_rsp_t rsp;

  timer_pool_mirror mirror = new();
  int unsigned      cycle_count = 0;

  software_timer_pool_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp      (rsp)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Monitor. Everything here is sampled at the rising edge, before the block's
  // registers update, so a command beat is exactly start high with busy low.
  // Results are checked before the command of the same edge is noted: a result
  // can never come from a command accepted at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid === 1'b1) begin
        mirror.check_reply(rsp);
      end
      if (start === 1'b1 && busy === 1'b0) begin
        mirror.note_command(req);
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("software_timer_pool_unit verification failed");
      $finish;
    end
  end

  function automatic stp_req_t make_cmd(logic [2:0] action, logic [4:0] slot,
                                        logic [15:0] ticks, logic rep);
    stp_req_t c;
    c.action    = action;
    c.slot      = slot;
    c.ticks     = ticks;
    c.repeating = rep;
    return c;
  endfunction

  // Present one command and return at the edge that takes its beat. The caller
  // may present the next command right away, which keeps start high without a
  // second assignment in the same step.
  task automatic issue(stp_req_t c);
    req   <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Idle the command side for a number of cycles, starting at an accept edge.
  task automatic pause(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Directed opening: an empty pool, unused action codes, both kinds of slot,
  // the extremes of the delay field, polls of counting and expired slots, a
  // task's expiry on its very first tick, and clears of every kind of slot.
  task automatic run_directed();
    issue(make_cmd(ACT_TICK, 0, 0, 0));
    issue(make_cmd(ACT_POLL, 5'(SLOT_TOP), 16'h8000, 1));   // slot never handed out
    issue(make_cmd(ACT_CLEAR, 5, 16'hFFFF, 0));         // clear of a free slot is ignored
    for (int a = ACT_CLEAR + 1; a <= ACT_TOP; a++) begin
      issue(make_cmd(3'(a), 5'($urandom_range(0, SLOT_TOP)), 16'($urandom),
                     1'($urandom_range(0, 1))));
    end
    issue(make_cmd(ACT_ALLOC, 0, 0, 0));                // slot 0: delay timer
    issue(make_cmd(ACT_CREATE, 0, 16'd2, 1));           // slot 1: task, period 2
    issue(make_cmd(ACT_CREATE, 0, 16'hFFFF, 0));        // slot 2: task, period forced to zero
    issue(make_cmd(ACT_ALLOC, 0, 0, 0));                // slot 3: delay timer
    issue(make_cmd(ACT_POLL, 0, 16'd0, 0));             // start with the shortest delay
    issue(make_cmd(ACT_POLL, 0, 16'd5, 0));             // already counting: no change
    issue(make_cmd(ACT_POLL, 3, 16'hFFFF, 0));          // longest delay
    pause(3);
    issue(make_cmd(ACT_TICK, 0, 0, 0));                 // slot 0 and both tasks expire
    issue(make_cmd(ACT_TICK, 0, 0, 0));
    issue(make_cmd(ACT_TICK, 0, 0, 0));
    issue(make_cmd(ACT_POLL, 0, 16'd3, 0));             // expired: no restart
    issue(make_cmd(ACT_CLEAR, 0, 0, 0));
    issue(make_cmd(ACT_POLL, 0, 16'd1, 0));             // cleared, so it starts again
    issue(make_cmd(ACT_TICK, 0, 0, 0));
    issue(make_cmd(ACT_TICK, 0, 0, 0));
    issue(make_cmd(ACT_POLL, 1, 16'd4, 1));             // poll of a task slot
    issue(make_cmd(ACT_CLEAR, 1, 0, 0));
    issue(make_cmd(ACT_TICK, 0, 0, 0));
    issue(make_cmd(ACT_CLEAR, 3, 0, 0));                // clear while counting
    issue(make_cmd(ACT_POLL, 3, 16'd0, 0));
  endtask

  // Random command. Slots mostly point at handed-out timers so that polls and
  // clears do real work; delays and periods are mostly short so that timers
  // actually expire. Late in the run allocation gets heavier to fill the pool.
  function automatic stp_req_t random_command(int unsigned n);
    stp_req_t    c;
    int unsigned roll;
    int unsigned alloc_share;
    alloc_share = (n >= RANDOM_ITEMS * 2 / 3) ? 25 : 5;
    roll        = $urandom_range(0, 99);
    if (mirror.slots_used == 0 || $urandom_range(0, 4) == 0) begin
      c.slot = 5'($urandom_range(0, SLOT_TOP));
    end else begin
      c.slot = 5'($urandom_range(0, mirror.slots_used - 1));
    end
    c.ticks     = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    c.repeating = 1'($urandom_range(0, 1));
    if (roll < alloc_share) begin
      c.action = ACT_ALLOC;
    end else if (roll < alloc_share + 4) begin
      c.action = ACT_CREATE;
    end else if (roll < alloc_share + 34) begin
      c.action = ACT_TICK;
    end else if (roll < alloc_share + 62) begin
      c.action = ACT_POLL;
    end else if (roll < 97) begin
      c.action = ACT_CLEAR;
    end else begin
      c.action = 3'($urandom_range(ACT_CLEAR + 1, ACT_TOP));
    end
    return c;
  endfunction

  // Random commands in bursts; about one burst in four runs straight into the
  // next one with no gap, the rest are followed by a short idle stretch.
  task automatic run_random();
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 10);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        issue(random_command(sent));
        sent++;
      end
      if (gap > 0) begin
        pause(gap);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    start <= 1'b0;
    // Waiting for an edge lets the monitor note the final beat before the queue is read.
    @(posedge clk);
    while (mirror.awaited.size() != 0) @(posedge clk);
    // A tick may still be walking slots that produce nothing; any stray
    // result in this window is flagged by the monitor.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.mismatch_count == 0 && mirror.awaited.size() == 0) begin
      $display("software_timer_pool_unit verification clean");
    end else begin
      $display("software_timer_pool_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/stp_pkg.sv
rtl/stp_ram.sv
rtl/software_timer_pool_unit.sv
bench/stp_timer_pool_mirror_pkg.sv
bench/tb_top.sv
